/* rtl/ofc_pkg.sv */
package ofc_pkg;

  localparam int CELL_W = 8;
  localparam int CFG_W  = 9;

  localparam logic       OP_WRITE = 1'b0;
  localparam logic       OP_QUERY = 1'b1;

  localparam logic [1:0] CFG_MAP_WIDTH      = 2'd0;
  localparam logic [1:0] CFG_MAP_HEIGHT     = 2'd1;
  localparam logic [1:0] CFG_OPEN_THRESHOLD = 2'd2;

  localparam logic [8:0] MAP_WIDTH_RST      = 9'd256;
  localparam logic [8:0] MAP_HEIGHT_RST     = 9'd256;
  localparam logic [6:0] OPEN_THRESHOLD_RST = 7'd25;

  localparam logic signed [CELL_W-1:0] CELL_UNKNOWN = -8'sd1;

  typedef struct packed {
    logic                      op;
    logic [7:0]                cell_x;
    logic [7:0]                cell_y;
    logic signed [CELL_W-1:0]  cell_value;
  } req_word_t;

  typedef struct packed {
    logic is_frontier;
    logic is_open;
    logic has_open_neighbour;
    logic out_of_range;
  } rsp_word_t;

  typedef struct packed {
    logic [8:0] map_width;
    logic [8:0] map_height;
    logic [6:0] open_threshold;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WRITE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_DONE
  } state_t;

  function automatic logic cell_open(logic signed [CELL_W-1:0] v, logic [6:0] thr);
    return !v[CELL_W-1] && (v[CELL_W-2:0] <= thr);
  endfunction

endpackage

/* rtl/ofc_grid_mem.sv */
module ofc_grid_mem
  import ofc_pkg::*;
#(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr_a,
  input  logic [AW-1:0]     raddr_b,
  output logic [CELL_W-1:0] rdata_a,
  output logic [CELL_W-1:0] rdata_b
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* rtl/ofc_seq.sv */
module ofc_seq
  import ofc_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int AW         = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_word_t         req_data,
  input  logic              room,
  output logic              rsp_load,
  output rsp_word_t         rsp_next,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [CELL_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr_a,
  output logic [AW-1:0]     mem_raddr_b,
  input  logic [CELL_W-1:0] mem_rdata_a,
  input  logic [CELL_W-1:0] mem_rdata_b
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  state_t state, state_next;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  logic                     op;
  logic [7:0]               x;
  logic [7:0]               y;
  logic signed [CELL_W-1:0] value;
  logic                     in_map;
  logic                     n_en, s_en, e_en, w_en;
  logic [AW-1:0]            base;
  logic                     c_open, c_unk, nb;

  logic [8+WW-1:0] prod;
  logic [AW-1:0]   centre;
  logic [AW-1:0]   w_ext;
  logic            nb_all;

  assign w_eff = (32'(cfg.map_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg.map_width);
  assign h_eff = (32'(cfg.map_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg.map_height);

  assign prod   = y * w_eff;
  assign centre = base + AW'(x);
  assign w_ext  = AW'(w_eff);
  assign nb_all = nb | (w_en & cell_open(mem_rdata_a, cfg.open_threshold));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (req_valid) state_next = ST_MUL;
      ST_MUL: begin
        if (op == OP_WRITE)  state_next = ST_WRITE;
        else if (in_map)     state_next = ST_RD0;
        else                 state_next = ST_DONE;
      end
      ST_WRITE: state_next = ST_IDLE;
      ST_RD0:   state_next = ST_RD1;
      ST_RD1:   state_next = ST_RD2;
      ST_RD2:   state_next = ST_DONE;
      ST_DONE:  if (room) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // centre and north, then south and east, then west
  always_comb begin
    req_stall   = 1'b1;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr_a = centre;
    mem_raddr_b = centre;
    rsp_load    = 1'b0;
    case (state)
      ST_IDLE:  req_stall = 1'b0;
      ST_WRITE: mem_we = in_map;
      ST_RD0: begin
        mem_re      = 1'b1;
        mem_raddr_b = centre - w_ext;
      end
      ST_RD1: begin
        mem_re      = 1'b1;
        mem_raddr_a = centre + w_ext;
        mem_raddr_b = centre + AW'(1);
      end
      ST_RD2: begin
        mem_re      = 1'b1;
        mem_raddr_a = centre - AW'(1);
      end
      ST_DONE:  rsp_load = room;
      default: ;
    endcase
  end

  assign mem_waddr = centre;
  assign mem_wdata = value;

  always_comb begin
    if (in_map) begin
      rsp_next.is_frontier        = c_unk & nb_all;
      rsp_next.is_open            = c_open;
      rsp_next.has_open_neighbour = nb_all;
      rsp_next.out_of_range       = 1'b0;
    end else begin
      rsp_next.is_frontier        = 1'b0;
      rsp_next.is_open            = 1'b0;
      rsp_next.has_open_neighbour = 1'b0;
      rsp_next.out_of_range       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          op     <= req_data.op;
          x      <= req_data.cell_x;
          y      <= req_data.cell_y;
          value  <= req_data.cell_value;
          in_map <= (32'(req_data.cell_x) < 32'(w_eff)) && (32'(req_data.cell_y) < 32'(h_eff));
          n_en   <= req_data.cell_y != 8'd0;
          w_en   <= req_data.cell_x != 8'd0;
          s_en   <= (32'(req_data.cell_y) + 32'd1) < 32'(h_eff);
          e_en   <= (32'(req_data.cell_x) + 32'd1) < 32'(w_eff);
        end
      end
      ST_MUL: begin
        base <= AW'(prod);
        nb   <= 1'b0;
      end
      ST_RD1: begin
        c_open <= cell_open(mem_rdata_a, cfg.open_threshold);
        c_unk  <= mem_rdata_a == CELL_UNKNOWN;
        nb     <= nb | (n_en & cell_open(mem_rdata_b, cfg.open_threshold));
      end
      ST_RD2: begin
        nb <= nb | (s_en & cell_open(mem_rdata_a, cfg.open_threshold))
                 | (e_en & cell_open(mem_rdata_b, cfg.open_threshold));
      end
      default: ;
    endcase
  end

endmodule

/* rtl/occupancy_frontier_classifier_top.sv */
// channel  | handshake                    | word
// req      | req_valid / req_stall        | req_data  (op, cell_x, cell_y, cell_value)
// rsp      | rsp_valid / rsp_stall        | rsp_data  (four flags, one per query)
// cfg      | cfg_we                       | cfg_index, cfg_data
//
// A write takes an address multiply, then the write. An in-map query takes an address
// multiply, then three read steps on the two read ports of the grid memory, then classify.
// An out-of-map query skips the reads. One word is in work at a time.
// rst resets control state, configuration and rsp_valid; grid contents are undefined until written.
// A result sits in the output register; a new word is taken while it waits.
// A query finishing while that register is still full and stalled holds in its last step.
module occupancy_frontier_classifier_top
  import ofc_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_word_t        req_data,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_word_t        rsp_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  cfg_t      cfg;
  logic      room;
  logic      rsp_load;
  rsp_word_t rsp_next;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [CELL_W-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_width      <= MAP_WIDTH_RST;
      cfg.map_height     <= MAP_HEIGHT_RST;
      cfg.open_threshold <= OPEN_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAP_WIDTH:      cfg.map_width      <= cfg_data;
        CFG_MAP_HEIGHT:     cfg.map_height     <= cfg_data;
        CFG_OPEN_THRESHOLD: cfg.open_threshold <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign room = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_data <= rsp_next;
    end
  end

  ofc_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_data    (req_data),
    .room        (room),
    .rsp_load    (rsp_load),
    .rsp_next    (rsp_next),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b)
  );

  ofc_grid_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_grid (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

endmodule
